FILE: hw/rtl/metu_pkg.sv
// ----------------------------------------------------------------------------
// metu_pkg
// Shared types, register indexes and reset constants of the multi-turn
// encoder tracker.
// ----------------------------------------------------------------------------
package metu_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DIVISOR_W     = 16;

    localparam logic [15:0] CPR_RESET   = 16'd8192;
    localparam logic [7:0]  GEAR_RESET  = 8'd19;
    localparam logic [14:0] TOL_RESET   = 15'd10;
    localparam logic [15:0] LIMIT_RESET = 16'd256;
    localparam logic        EN_RESET    = 1'b0;
    localparam logic [15:0] STILL_MAX   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTS_PER_REV  = 3'd0,
        REG_GEAR_RATIO      = 3'd1,
        REG_STALL_TOLERANCE = 3'd2,
        REG_STALL_LIMIT     = 3'd3,
        REG_STALL_ENABLE    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_UPDATE,
        ST_MUL_A,
        ST_DIV_A,
        ST_MUL_R,
        ST_DIV_R,
        ST_DONE
    } metu_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hw/rtl/metu_if.sv
// ----------------------------------------------------------------------------
// metu channel interfaces
// Sample, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface metu_sample_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] raw_position;
    logic signed [15:0] raw_speed;

    modport source (output valid, output req_type, output raw_position,
                    output raw_speed, input ready);
    modport sink   (input valid, input req_type, input raw_position,
                    input raw_speed, output ready);
endinterface

interface metu_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] acceleration;
    logic signed [15:0] position_delta;
    logic signed [31:0] geared_turns;
    logic signed [31:0] total_geared_turns;
    logic               stalled;

    modport source (output valid, output acceleration, output position_delta,
                    output geared_turns, output total_geared_turns,
                    output stalled, input ready);
    modport sink   (input valid, input acceleration, input position_delta,
                    input geared_turns, input total_geared_turns,
                    input stalled, output ready);
endinterface

interface metu_cfg_if import metu_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/metu_divu.sv
// ----------------------------------------------------------------------------
// metu_divu
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module metu_divu
    import metu_pkg::*;
#(
    parameter int DW = ACC_WIDTH_DEF + 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [DW-1:0]        quotient,
    output div_stat_t            stat
);

    localparam int CW = $clog2(DW + 1);

    logic [DIVISOR_W:0]   rem_reg;
    logic [DIVISOR_W:0]   rem_next;
    logic [DW-1:0]        work_reg;
    logic [DW-1:0]        work_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   rem_sh;
    logic                 fits;

    // remainder stays below the divisor, so one spare bit covers the shift
    always_comb
    begin
        rem_sh    = {rem_reg[DIVISOR_W-1:0], work_reg[DW-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        rem_next  = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        work_next = {work_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            work_reg <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                rem_reg  <= '0;
                work_reg <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                work_reg <= work_next;
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/multiturn_encoder_tracker_unit.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_tracker_unit
// Multi-turn position tracker with unwrap, geared turns and stall detection.
// ----------------------------------------------------------------------------
// For each sample word the delta and count update states run first; then each
// of the two counts is scaled by the gear ratio and goes through the single
// shared bit-serial divider, one quotient bit per cycle over ACC_WIDTH+8 bits,
// before the quotient is picked up. A zero request goes straight to the done
// state. The sample channel is ready only between words; a finished result
// waits in the output register and the next sample is taken meanwhile.
// Configuration is written through the cfg channel, index as in the register
// list; the user must write it only while the block is idle, which the block
// itself does not enforce.
module multiturn_encoder_tracker_unit
    import metu_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    metu_sample_if.sink  sample,
    metu_result_if.source result,
    metu_cfg_if.sink     cfg
);

    localparam int PW = ACC_WIDTH + 8;

    // configuration
    logic [15:0] cpr_reg;
    logic [7:0]  gear_reg;
    logic [14:0] tol_reg;
    logic [15:0] limit_reg;
    logic        stall_en_reg;

    metu_state_t state_reg, state_next;

    logic signed [15:0]          pos_reg, pos_next;
    logic signed [15:0]          spd_reg, spd_next;
    logic signed [15:0]          prev_speed_reg, prev_speed_next;
    logic signed [15:0]          last_position_reg, last_position_next;
    logic signed [ACC_WIDTH-1:0] actual_count_reg, actual_count_next;
    logic signed [ACC_WIDTH-1:0] recorded_count_reg, recorded_count_next;
    logic                        initialized_reg, initialized_next;
    logic [15:0]                 still_run_count_reg, still_run_count_next;

    logic signed [16:0] accel_reg, accel_next;
    logic signed [15:0] delta_reg, delta_next;
    logic signed [31:0] geared_reg, geared_next;
    logic signed [31:0] total_reg, total_next;
    logic               stalled_reg, stalled_next;
    logic               neg_reg, neg_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [16:0] res_accel_reg, res_accel_next;
    logic signed [15:0] res_delta_reg, res_delta_next;
    logic signed [31:0] res_geared_reg, res_geared_next;
    logic signed [31:0] res_total_reg, res_total_next;
    logic               res_stalled_reg, res_stalled_next;

    logic                 sample_acc;
    logic                 out_load;
    logic                 div_start;
    logic [PW-1:0]        div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [PW-1:0]        div_quot;
    div_stat_t            div_stat;

    // datapath temporaries
    logic signed [15:0]          last_eff;
    logic signed [17:0]          diff;
    logic signed [17:0]          half;
    logic signed [17:0]          cpr_s;
    logic signed [15:0]          delta_sat;
    logic [16:0]                 delta_mag;
    logic signed [ACC_WIDTH-1:0] count_sel;
    logic [ACC_WIDTH-1:0]        count_abs;

    function automatic logic [31:0] sat_turns(input logic neg, input logic [PW-1:0] mag);
        logic [PW-32:0] hi;
        logic [30:0]    lo;
        logic [31:0]    r;
        hi = mag[PW-1:31];
        lo = mag[30:0];
        if (!neg)
            r = (|hi) ? 32'h7FFF_FFFF : {1'b0, lo};
        else if ((hi > (PW-31)'(1)) || ((hi == (PW-31)'(1)) && (|lo)))
            r = 32'h8000_0000;
        else
            r = 32'd0 - mag[31:0];
        return r;
    endfunction

    metu_divu #(
        .DW (PW)
    ) u_divu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign sample_acc = sample.valid && sample.ready;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (sample_acc) state_next = sample.req_type ? ST_DONE : ST_DELTA;
            ST_DELTA:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_DIV_A;
            ST_DIV_A:  if (div_stat.done) state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_DIV_R;
            ST_DIV_R:  if (div_stat.done) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE);
        cfg.ready    = 1'b1;

        pos_next             = pos_reg;
        spd_next             = spd_reg;
        prev_speed_next      = prev_speed_reg;
        last_position_next   = last_position_reg;
        actual_count_next    = actual_count_reg;
        recorded_count_next  = recorded_count_reg;
        initialized_next     = initialized_reg;
        still_run_count_next = still_run_count_reg;
        accel_next           = accel_reg;
        delta_next           = delta_reg;
        geared_next          = geared_reg;
        total_next           = total_reg;
        stalled_next         = stalled_reg;
        neg_next             = neg_reg;

        // unwrap by one revolution, then clamp to the delta range
        last_eff = initialized_reg ? last_position_reg : pos_reg;
        diff     = 18'(pos_reg) - 18'(last_eff);
        half     = $signed({2'b00, cpr_reg >> 1});
        cpr_s    = $signed({2'b00, cpr_reg});
        if (diff < -half)
            diff = diff + cpr_s;
        if (diff > half)
            diff = diff - cpr_s;
        if (diff > 18'sd32767)
            delta_sat = 16'sh7FFF;
        else if (diff < -18'sd32768)
            delta_sat = 16'sh8000;
        else
            delta_sat = diff[15:0];

        delta_mag = delta_reg[15] ? (17'd0 - {1'b1, delta_reg}) : {1'b0, delta_reg};

        count_sel    = (state_reg == ST_MUL_R) ? recorded_count_reg : actual_count_reg;
        count_abs    = count_sel[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - count_sel) : count_sel;
        div_dividend = PW'(count_abs) * PW'(gear_reg);
        div_divisor  = (cpr_reg == '0) ? DIVISOR_W'(1) : cpr_reg;
        div_start    = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_R);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    pos_next = sample.raw_position;
                    spd_next = sample.raw_speed;
                    if (sample.req_type)
                    begin
                        actual_count_next   = '0;
                        recorded_count_next = '0;
                        initialized_next    = 1'b0;
                        accel_next          = '0;
                        delta_next          = '0;
                        geared_next         = '0;
                        total_next          = '0;
                        stalled_next        = 1'b0;
                    end
                end
            end
            ST_DELTA:
            begin
                accel_next         = 17'(spd_reg) - 17'(prev_speed_reg);
                prev_speed_next    = spd_reg;
                delta_next         = delta_sat;
                last_position_next = pos_reg;
                initialized_next   = 1'b1;
                // first sample seeds the actual count only
                if (!initialized_reg)
                    actual_count_next = ACC_WIDTH'(pos_reg);
            end
            ST_UPDATE:
            begin
                actual_count_next   = actual_count_reg + ACC_WIDTH'(delta_reg);
                recorded_count_next = recorded_count_reg + ACC_WIDTH'(delta_reg);
                if (stall_en_reg)
                begin
                    if (delta_mag <= {2'b00, tol_reg})
                    begin
                        if (still_run_count_reg != STILL_MAX)
                            still_run_count_next = still_run_count_reg + 16'd1;
                    end
                    else
                        still_run_count_next = '0;
                end
            end
            ST_MUL_A:
            begin
                neg_next     = count_sel[ACC_WIDTH-1];
                stalled_next = stall_en_reg && (still_run_count_reg > limit_reg);
            end
            ST_DIV_A:
            begin
                if (div_stat.done)
                    geared_next = sat_turns(neg_reg, div_quot);
            end
            ST_MUL_R:
            begin
                neg_next = count_sel[ACC_WIDTH-1];
            end
            ST_DIV_R:
            begin
                if (div_stat.done)
                    total_next = sat_turns(neg_reg, div_quot);
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // output register, refilled once the waiting word is gone
        out_valid_next   = out_valid_reg && !result.ready;
        res_accel_next   = res_accel_reg;
        res_delta_next   = res_delta_reg;
        res_geared_next  = res_geared_reg;
        res_total_next   = res_total_reg;
        res_stalled_next = res_stalled_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            res_accel_next   = accel_reg;
            res_delta_next   = delta_reg;
            res_geared_next  = geared_reg;
            res_total_next   = total_reg;
            res_stalled_next = stalled_reg;
        end

        result.valid              = out_valid_reg;
        result.acceleration       = res_accel_reg;
        result.position_delta     = res_delta_reg;
        result.geared_turns       = res_geared_reg;
        result.total_geared_turns = res_total_reg;
        result.stalled            = res_stalled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg      <= CPR_RESET;
            gear_reg     <= GEAR_RESET;
            tol_reg      <= TOL_RESET;
            limit_reg    <= LIMIT_RESET;
            stall_en_reg <= EN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_COUNTS_PER_REV:  cpr_reg      <= cfg.data[15:0];
                REG_GEAR_RATIO:      gear_reg     <= cfg.data[7:0];
                REG_STALL_TOLERANCE: tol_reg      <= cfg.data[14:0];
                REG_STALL_LIMIT:     limit_reg    <= cfg.data[15:0];
                REG_STALL_ENABLE:    stall_en_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            prev_speed_reg      <= '0;
            last_position_reg   <= '0;
            actual_count_reg    <= '0;
            recorded_count_reg  <= '0;
            initialized_reg     <= 1'b0;
            still_run_count_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            prev_speed_reg      <= prev_speed_next;
            last_position_reg   <= last_position_next;
            actual_count_reg    <= actual_count_next;
            recorded_count_reg  <= recorded_count_next;
            initialized_reg     <= initialized_next;
            still_run_count_reg <= still_run_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        spd_reg         <= spd_next;
        accel_reg       <= accel_next;
        delta_reg       <= delta_next;
        geared_reg      <= geared_next;
        total_reg       <= total_next;
        stalled_reg     <= stalled_next;
        neg_reg         <= neg_next;
        res_accel_reg   <= res_accel_next;
        res_delta_reg   <= res_delta_next;
        res_geared_reg  <= res_geared_next;
        res_total_reg   <= res_total_next;
        res_stalled_reg <= res_stalled_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (state_reg != ST_IDLE))
        else $error("sample taken but sequencer stayed idle");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_acc && sample.req_type) |=>
            ((actual_count_reg == '0) && (recorded_count_reg == '0) && !initialized_reg))
        else $error("zero request did not clear counts");

    a_still_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && !stall_en_reg) |=> $stable(still_run_count_reg))
        else $error("still run count moved with stall detection off");

endmodule

FILE: sim/multiturn_encoder_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_tracker_unit_test
// Self-checking bench for the multi-turn encoder tracker. A short scripted
// sequence covers reset, field extremes, unwrap, saturation, zero requests
// and stall detection. Randomised phases follow, each under a fresh register
// setting, including long spins whose count later saturates the geared turns.
// Each result is checked against the behavioural tracker or a scripted value.
// ----------------------------------------------------------------------------
module multiturn_encoder_tracker_unit_test
    import metu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W          = ACC_WIDTH_DEF;
    localparam int IDLE_PCT       = 27;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 2 * ACC_W + 20;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_ZERO   = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t          req;
        logic signed [15:0] pos;
        logic signed [15:0] spd;
    } sample_word_t;

    typedef struct packed {
        logic signed [16:0] accel;
        logic signed [15:0] delta;
        logic signed [31:0] turns;
        logic signed [31:0] total_turns;
        logic               stalled;
    } track_result_t;

    typedef enum {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        cfg_reg_t      reg_sel;
        logic [15:0]   reg_val;
        sample_word_t  word;
        bit            typed;
        track_result_t want;
    } script_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    metu_sample_if sample_ch ();
    metu_result_if result_ch ();
    metu_cfg_if    cfg_ch ();

    multiturn_encoder_tracker_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // register mirror
    logic [15:0] cpr_r      = CPR_RESET;
    logic [7:0]  gear_r     = GEAR_RESET;
    logic [14:0] tol_r      = TOL_RESET;
    logic [15:0] limit_r    = LIMIT_RESET;
    logic        stall_en_r = EN_RESET;

    // tracker state
    logic signed [15:0]      spd_hist  = '0;
    logic signed [15:0]      pos_hist  = '0;
    logic signed [ACC_W-1:0] turns_acc = '0;
    logic signed [ACC_W-1:0] total_acc = '0;
    logic                    seeded    = 1'b0;
    logic [15:0]             still_run = '0;

    track_result_t pending[$];
    script_row_t   script[$];

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned hold_asks    = 0;
    int unsigned hold_served  = 0;
    int unsigned hold_left    = 0;
    bit          steady       = 1'b0;

    logic signed [15:0] aim_pos = '0;
    logic signed [15:0] aim_spd = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] scale_turns(logic signed [ACC_W-1:0] cnt);
        longint div;
        longint q;
        div = (cpr_r == '0) ? 64'sd1 : longint'(cpr_r);
        q = longint'(cnt) * longint'(gear_r) / div;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return 32'(q);
    endfunction

    function automatic track_result_t track_step(sample_word_t w);
        track_result_t r;
        longint d;
        longint half;
        longint mag;
        r = '0;
        if (w.req == REQ_ZERO)
        begin
            turns_acc = '0;
            total_acc = '0;
            seeded    = 1'b0;
            return r;
        end
        r.accel  = 17'(longint'(w.spd) - longint'(spd_hist));
        spd_hist = w.spd;
        // first word after reset or a zero request seeds the actual count
        if (!seeded)
        begin
            seeded    = 1'b1;
            pos_hist  = w.pos;
            turns_acc = ACC_W'(longint'(w.pos));
        end
        d    = longint'(w.pos) - longint'(pos_hist);
        half = longint'(cpr_r) / 2;
        if (d < -half)
            d = d + longint'(cpr_r);
        if (d > half)
            d = d - longint'(cpr_r);
        if (d > 64'sd32767)
            d = 64'sd32767;
        if (d < -64'sd32768)
            d = -64'sd32768;
        total_acc = ACC_W'(longint'(total_acc) + d);
        turns_acc = ACC_W'(longint'(turns_acc) + d);
        pos_hist  = w.pos;
        if (stall_en_r)
        begin
            mag = (d < 0) ? -d : d;
            if (mag <= longint'(tol_r))
            begin
                if (still_run != STILL_MAX)
                    still_run = still_run + 16'd1;
            end
            else
                still_run = '0;
            r.stalled = (still_run > limit_r);
        end
        r.delta       = 16'(d);
        r.turns       = scale_turns(turns_acc);
        r.total_turns = scale_turns(total_acc);
        return r;
    endfunction

    function automatic track_result_t outcome(longint a, longint dl, longint g, longint t,
                                              bit st);
        track_result_t r;
        r.accel       = 17'(a);
        r.delta       = 16'(dl);
        r.turns       = 32'(g);
        r.total_turns = 32'(t);
        r.stalled     = st;
        return r;
    endfunction

    function automatic void add_word(req_kind_t req, logic signed [15:0] pos,
                                     logic signed [15:0] spd, bit typed, track_result_t want);
        script_row_t row;
        row.kind    = ROW_WORD;
        row.reg_sel = REG_COUNTS_PER_REV;
        row.reg_val = '0;
        row.word    = '{req, pos, spd};
        row.typed   = typed;
        row.want    = want;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(cfg_reg_t sel, logic [15:0] val);
        script_row_t row;
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        row.word    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic logic [15:0] pick16(logic [15:0] lo, logic [15:0] hi,
                                           logic [15:0] mid);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return mid;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic send_word(sample_word_t w, bit typed, track_result_t want);
        track_result_t calc;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.req_type     <= w.req;
        sample_ch.raw_position <= w.pos;
        sample_ch.raw_speed    <= w.spd;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        calc = track_step(w);
        pending.push_back(typed ? want : calc);
    endtask

    // wait until every word in flight has come back
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t sel, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (sel)
            REG_COUNTS_PER_REV:  cpr_r      = val;
            REG_GEAR_RATIO:      gear_r     = val[7:0];
            REG_STALL_TOLERANCE: tol_r      = val[14:0];
            REG_STALL_LIMIT:     limit_r    = val;
            REG_STALL_ENABLE:    stall_en_r = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic shuffle_config();
        write_reg(REG_COUNTS_PER_REV, pick16(16'd2, 16'd32768,
                  $urandom_range(0, 1) ? 16'($urandom_range(2, 64))
                                       : 16'($urandom_range(2, 32768))));
        write_reg(REG_GEAR_RATIO, pick16(16'd1, 16'd255, 16'($urandom_range(0, 255))));
        write_reg(REG_STALL_TOLERANCE, pick16(16'd0, 16'd32767, 16'($urandom_range(0, 40))));
        write_reg(REG_STALL_LIMIT, pick16(16'd0, 16'd65534, 16'($urandom_range(0, 30))));
        write_reg(REG_STALL_ENABLE, 16'($urandom_range(0, 1)));
    endtask

    // mostly small moves around the last position, some wide ones and zero requests
    task automatic run_phase(int unsigned count, int unsigned jitter);
        sample_word_t w;
        int unsigned  roll;
        for (int unsigned n = 0; n < count; n++)
        begin
            roll  = $urandom_range(0, 99);
            w.req = REQ_SAMPLE;
            if ($urandom_range(0, 9) == 0)
                w.spd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
                w.spd = aim_spd + 16'($urandom_range(0, 600)) - 16'sd300;
            if (roll < 4)
            begin
                w.req = REQ_ZERO;
                w.pos = 16'($urandom_range(0, 65535));
                w.spd = 16'($urandom_range(0, 65535));
            end
            else if (roll < 64)
                w.pos = aim_pos + 16'($urandom_range(0, 2 * jitter)) - 16'(jitter);
            else if (roll < 89)
                w.pos = aim_pos + 16'($urandom_range(0, cpr_r)) - 16'(cpr_r / 2);
            else
                w.pos = 16'($urandom_range(0, 65535));
            if (w.req == REQ_SAMPLE)
            begin
                aim_pos = w.pos;
                aim_spd = w.spd;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // near half-turn steps in one direction pile up a large count
    task automatic spin(int unsigned count, bit upward);
        sample_word_t w;
        logic [15:0]  stride;
        w.req = REQ_ZERO;
        w.pos = aim_pos;
        w.spd = aim_spd;
        send_word(w, 1'b0, '0);
        w.req = REQ_SAMPLE;
        for (int unsigned n = 0; n < count; n++)
        begin
            stride  = 16'($urandom_range(31000, 32767));
            w.pos   = upward ? aim_pos + stride : aim_pos - stride;
            w.spd   = 16'($urandom_range(0, 65535));
            aim_pos = w.pos;
            aim_spd = w.spd;
            send_word(w, 1'b0, '0);
        end
    endtask

    // result side: check each word, then choose ready for the next edge
    initial
    begin
        track_result_t got;
        track_result_t want;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.accel       = result_ch.acceleration;
                got.delta       = result_ch.position_delta;
                got.turns       = result_ch.geared_turns;
                got.total_turns = result_ch.total_geared_turns;
                got.stalled     = result_ch.stalled;
                results_seen++;
                if (pending.size() == 0)
                    report_mismatch("result word with nothing outstanding");
                else
                begin
                    want = pending.pop_front();
                    check_field("acceleration", got.accel, want.accel);
                    check_field("position_delta", got.delta, want.delta);
                    check_field("geared_turns", got.turns, want.turns);
                    check_field("total_geared_turns", got.total_turns, want.total_turns);
                    check_field("stalled", got.stalled, want.stalled);
                end
            end
            result_ch.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // long back-pressure stretches, started by the stimulus
    always @(posedge clk)
    begin
        if (hold_served != hold_asks)
        begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin
        int unsigned quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("multiturn_encoder_tracker_unit regression: fail");
        $finish;
    end

    initial
    begin
        sample_ch.valid        = 1'b0;
        sample_ch.req_type     = REQ_SAMPLE;
        sample_ch.raw_position = '0;
        sample_ch.raw_speed    = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_COUNTS_PER_REV;
        cfg_ch.data            = '0;

        // reset settings, then extremes, zero divisor, zero gear and stalls
        add_word(REQ_SAMPLE, 16'sd0, 16'sd0, 1'b1, outcome(0, 0, 0, 0, 0));
        add_word(REQ_SAMPLE, 16'sd100, 16'sh7FFF, 1'b1, outcome(32767, 100, 0, 0, 0));
        add_word(REQ_SAMPLE, 16'sd8000, 16'sh8000, 1'b1, outcome(-65535, -292, 0, 0, 0));
        add_word(REQ_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b0, '0);
        add_word(REQ_SAMPLE, 16'sh7FFF, 16'sd0, 1'b0, '0);
        add_word(REQ_ZERO, 16'sh7FFF, 16'shFFFF, 1'b1, outcome(0, 0, 0, 0, 0));
        add_word(REQ_SAMPLE, 16'sh8000, 16'shFFFF, 1'b1, outcome(-1, 0, -76, 0, 0));
        add_word(REQ_SAMPLE, -16'sd32700, 16'sd5, 1'b0, '0);
        add_cfg(REG_COUNTS_PER_REV, 16'd0);
        add_cfg(REG_GEAR_RATIO, 16'd255);
        add_cfg(REG_STALL_TOLERANCE, 16'd0);
        add_cfg(REG_STALL_LIMIT, 16'd0);
        add_cfg(REG_STALL_ENABLE, 16'd1);
        add_word(REQ_SAMPLE, -16'sd32700, 16'sd5, 1'b0, '0);
        add_word(REQ_SAMPLE, -16'sd32699, 16'sd5, 1'b0, '0);
        add_word(REQ_SAMPLE, 16'sh7FFF, 16'sd5, 1'b0, '0);
        add_cfg(REG_GEAR_RATIO, 16'd0);
        add_cfg(REG_STALL_TOLERANCE, 16'd32767);
        add_cfg(REG_STALL_LIMIT, 16'd65534);
        add_word(REQ_SAMPLE, 16'sd0, 16'sd0, 1'b0, '0);
        add_word(REQ_SAMPLE, 16'sh8000, 16'sh8000, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                if (i == 0 || script[i - 1].kind != ROW_CFG)
                    settle();
                write_reg(script[i].reg_sel, script[i].reg_val);
            end
            else
                send_word(script[i].word, script[i].typed, script[i].want);
        end

        for (int p = 0; p < 10; p++)
        begin
            settle();
            shuffle_config();
            // the receiver holds off while words keep coming
            if (p == 2 || p == 7)
                hold_asks <= hold_asks + 1;
            run_phase(90, (p % 3 == 0) ? 0 : $urandom_range(1, 24));
        end

        settle();
        write_reg(REG_COUNTS_PER_REV, 16'hFFFF);
        steady <= 1'b1;
        spin(320, 1'b1);
        settle();
        steady <= 1'b0;
        write_reg(REG_COUNTS_PER_REV, 16'd1);
        write_reg(REG_GEAR_RATIO, 16'd255);
        run_phase(15, 2);
        settle();
        write_reg(REG_COUNTS_PER_REV, 16'd0);
        run_phase(15, 2);

        settle();
        write_reg(REG_COUNTS_PER_REV, 16'hFFFF);
        spin(320, 1'b0);
        settle();
        write_reg(REG_COUNTS_PER_REV, 16'd1);
        run_phase(15, 2);

        settle();
        write_reg(REG_COUNTS_PER_REV, CPR_RESET);
        write_reg(REG_GEAR_RATIO, 16'(GEAR_RESET));
        write_reg(REG_STALL_TOLERANCE, 16'(TOL_RESET));
        write_reg(REG_STALL_LIMIT, LIMIT_RESET);
        write_reg(REG_STALL_ENABLE, 16'd1);
        run_phase(100, 6);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending.size()));
        if (mismatches == 0)
            $display("multiturn_encoder_tracker_unit regression: pass");
        else
            $display("multiturn_encoder_tracker_unit regression: fail");
        $finish;
    end

endmodule
